// ===== src/ctk_pkg.sv =====
// ============================================================================
// ctk_pkg
// Shared types, codes and constants of the capacitive touch key detector.
// ============================================================================
`timescale 1ns / 1ps

package ctk_pkg;

    localparam int unsigned SAMPLE_W = 16;     // charge-time count width
    localparam int unsigned SUM_W    = 20;     // calibration accumulator width
    localparam int unsigned GCNT_W   = 3;      // scan group counter width

    localparam int unsigned CAL_SAMPLES_DEFAULT   = 10;
    localparam int unsigned LOCKOUT_SCANS_DEFAULT = 3;

    localparam logic [SAMPLE_W-1:0] FAIL_LIMIT = 16'h7FFF;   // half counter range
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;

    localparam logic [GCNT_W-1:0] GROUP_SINGLE = 3'd3;
    localparam logic [GCNT_W-1:0] GROUP_CONT   = 3'd6;

    // input action codes
    localparam logic ACT_CAL  = 1'b0;
    localparam logic ACT_SCAN = 1'b1;

    // result kind codes
    localparam logic KIND_CAL  = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    typedef struct packed {
        logic                done;
        logic                failed;
        logic [SAMPLE_W-1:0] value;
    } t_cal_result;

    typedef struct packed {
        logic                done;
        logic                pressed;
        logic [SAMPLE_W-1:0] peak;
    } t_scan_result;

endpackage

// ===== src/ctk_if.sv =====
// ============================================================================
// ctk_if
// Valid/ready channels of the touch key detector: sample in, result out,
// and the mode register write channel.
// ============================================================================
`timescale 1ns / 1ps

interface ctk_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] sample;

    modport source (output valid, output action, output sample, input ready);
    modport sink   (input valid, input action, input sample, output ready);
endinterface

interface ctk_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        pressed;
    logic        calibration_failed;
    logic [15:0] baseline_value;
    logic [15:0] peak_value;

    modport source (output valid, output result_kind, output pressed,
                    output calibration_failed, output baseline_value,
                    output peak_value, input ready);
    modport sink   (input valid, input result_kind, input pressed,
                    input calibration_failed, input baseline_value,
                    input peak_value, output ready);
endinterface

interface ctk_cfg_if;
    logic valid;
    logic ready;
    logic data;     // continuous_mode

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/capacitive_touch_key_detector_unit.sv =====
// ============================================================================
// capacitive_touch_key_detector_unit
// Charge-time touch key detector. Takes one capture count per transaction
// and sustains one transaction per clock unless o_out.ready holds it back:
// each sample is latched in an input register, handled by one pass of
// combinational logic (calibration sum and trimmed mean via a single 20x21
// reciprocal multiply, or the scan-group compares) and lands in the result
// register as soon as that slot is free or its result is taken. Calibration
// samples (action 0) build the idle baseline; every CAL_SAMPLES-th one
// yields a result with the trimmed mean and a failure flag when it exceeds
// half the counter range. Scan samples (action 1) are grouped by three, or
// by six when continuous_mode is set; each finished group yields a result
// with its qualified peak and a press flag. In single mode a press
// clears the press flag of the next LOCKOUT_SCANS-1 groups, the count being
// reloaded on every in-window group. Samples that do not close a run or
// group yield no result. The mode register may only be written while no
// transaction is in flight.
// ============================================================================
`timescale 1ns / 1ps

module capacitive_touch_key_detector_unit #(
    parameter int unsigned CAL_SAMPLES   = ctk_pkg::CAL_SAMPLES_DEFAULT,
    parameter int unsigned LOCKOUT_SCANS = ctk_pkg::LOCKOUT_SCANS_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctk_cfg_if.sink       i_cfg,
    ctk_in_if.sink        i_in,
    ctk_out_if.source     o_out
);
    import ctk_pkg::*;

    // mode register, always writable
    logic r_continuous;

    // input register
    logic                r_in_valid;
    logic                r_action;
    logic [SAMPLE_W-1:0] r_sample;

    // result register
    logic                r_out_valid;
    logic                r_kind;
    logic                r_pressed;
    logic                r_failed;
    logic [SAMPLE_W-1:0] r_base_out;
    logic [SAMPLE_W-1:0] r_peak_out;

    logic                advance;   // result slot free after this edge
    logic                fire;      // latched sample processed this edge
    logic                cal_en, scan_en;
    logic [SAMPLE_W-1:0] baseline;
    t_cal_result         cal_res;
    t_scan_result        scan_res;

    assign advance = !r_out_valid || o_out.ready;
    assign fire    = r_in_valid && advance;
    assign cal_en  = fire && (r_action == ACT_CAL);
    assign scan_en = fire && (r_action == ACT_SCAN);

    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_continuous <= 1'b0;
        end else if (i_cfg.valid) begin
            r_continuous <= i_cfg.data;
        end
    end

    // Input stage: reloads whenever the latched sample moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_action <= i_in.action;
            r_sample <= i_in.sample;
        end
    end

    ctk_calib #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_calib (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (cal_en),
        .i_sample   (r_sample),
        .o_baseline (baseline),
        .o_res      (cal_res)
    );

    // Scan sees the baseline current at its step; a calibration finishing
    // at an earlier step has already updated it.
    ctk_scan #(
        .LOCKOUT_SCANS (LOCKOUT_SCANS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (scan_en),
        .i_continuous (r_continuous),
        .i_sample     (r_sample),
        .i_baseline   (baseline),
        .o_res        (scan_res)
    );

    // Result stage: holds until taken, refills in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= (cal_en && cal_res.done) || (scan_en && scan_res.done);
        end
    end

    always_ff @(posedge i_clk) begin
        if (cal_en) begin
            r_kind     <= KIND_CAL;
            r_pressed  <= 1'b0;
            r_failed   <= cal_res.failed;
            r_base_out <= cal_res.value;
            r_peak_out <= '0;
        end else if (scan_en) begin
            r_kind     <= KIND_SCAN;
            r_pressed  <= scan_res.pressed;
            r_failed   <= 1'b0;
            r_base_out <= baseline;
            r_peak_out <= scan_res.peak;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.result_kind        = r_kind;
    assign o_out.pressed            = r_pressed;
    assign o_out.calibration_failed = r_failed;
    assign o_out.baseline_value     = r_base_out;
    assign o_out.peak_value         = r_peak_out;

endmodule

// ===== src/ctk_calib.sv =====
// ============================================================================
// ctk_calib
// Calibration run: running sum, two smallest / two largest tracking and
// trimmed-mean baseline by reciprocal multiply.
// ============================================================================
`timescale 1ns / 1ps

module ctk_calib #(
    parameter int unsigned CAL_SAMPLES = ctk_pkg::CAL_SAMPLES_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [ctk_pkg::SAMPLE_W-1:0]  i_sample,
    output logic [ctk_pkg::SAMPLE_W-1:0]  o_baseline,
    output ctk_pkg::t_cal_result          o_res
);
    import ctk_pkg::*;

    localparam int unsigned CNT_W  = $clog2(CAL_SAMPLES + 1);
    localparam int unsigned DIV    = CAL_SAMPLES - 4;
    localparam int unsigned DIV_L  = $clog2(DIV);
    localparam int unsigned SH     = SUM_W + DIV_L;
    localparam int unsigned M_W    = SUM_W + 1;
    localparam int unsigned PROD_W = SUM_W + M_W;
    // ceil(2^SH / DIV): exact quotient for any SUM_W-bit dividend
    localparam logic [M_W-1:0] RECIP = M_W'(((64'd1 << SH) + DIV - 1) / DIV);

    logic [CNT_W-1:0]    r_count,  n_count;
    logic [SUM_W-1:0]    r_sum,    n_sum;
    logic [SAMPLE_W-1:0] r_small0, n_small0, r_small1, n_small1;
    logic [SAMPLE_W-1:0] r_large0, n_large0, r_large1, n_large1;
    logic [SAMPLE_W-1:0] r_baseline;
    logic                last;
    logic [SUM_W-1:0]    trimmed;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] quot;

    always_comb begin
        n_sum   = r_sum + SUM_W'(i_sample);
        n_count = r_count + CNT_W'(1);

        n_small0 = r_small0;
        n_small1 = r_small1;
        if (i_sample < r_small0) begin
            n_small1 = r_small0;
            n_small0 = i_sample;
        end else if (i_sample < r_small1) begin
            n_small1 = i_sample;
        end

        n_large0 = r_large0;
        n_large1 = r_large1;
        if (i_sample > r_large0) begin
            n_large1 = r_large0;
            n_large0 = i_sample;
        end else if (i_sample > r_large1) begin
            n_large1 = i_sample;
        end

        last    = (n_count == CNT_W'(CAL_SAMPLES));
        trimmed = n_sum - SUM_W'(n_small0) - SUM_W'(n_small1)
                        - SUM_W'(n_large0) - SUM_W'(n_large1);
        prod    = PROD_W'(trimmed) * PROD_W'(RECIP);
        quot    = prod[SH +: SAMPLE_W];

        o_res.done   = last;
        o_res.failed = (quot > FAIL_LIMIT);
        o_res.value  = quot;
    end

    assign o_baseline = r_baseline;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_sum      <= '0;
            r_small0   <= SAMPLE_MAX;
            r_small1   <= SAMPLE_MAX;
            r_large0   <= '0;
            r_large1   <= '0;
            r_baseline <= '0;
        end else if (i_en) begin
            if (last) begin
                r_count    <= '0;
                r_sum      <= '0;
                r_small0   <= SAMPLE_MAX;
                r_small1   <= SAMPLE_MAX;
                r_large0   <= '0;
                r_large1   <= '0;
                r_baseline <= quot;     // taken over even when flagged failed
            end else begin
                r_count  <= n_count;
                r_sum    <= n_sum;
                r_small0 <= n_small0;
                r_small1 <= n_small1;
                r_large0 <= n_large0;
                r_large1 <= n_large1;
            end
        end
    end

endmodule

// ===== src/ctk_scan.sv =====
// ============================================================================
// ctk_scan
// Scan group: valid-sample count, peak tracking, press window and lockout.
// ============================================================================
`timescale 1ns / 1ps

module ctk_scan #(
    parameter int unsigned LOCKOUT_SCANS = ctk_pkg::LOCKOUT_SCANS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_continuous,
    input  logic [ctk_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [ctk_pkg::SAMPLE_W-1:0]  i_baseline,
    output ctk_pkg::t_scan_result         o_res
);
    import ctk_pkg::*;

    localparam int unsigned LOCK_W = $clog2(LOCKOUT_SCANS + 1);
    localparam logic [GCNT_W-1:0] NEED_SINGLE = GCNT_W'(int'(GROUP_SINGLE) * 2 / 3);
    localparam logic [GCNT_W-1:0] NEED_CONT   = GCNT_W'(int'(GROUP_CONT) * 2 / 3);

    logic [GCNT_W-1:0]   r_gcnt,  n_gcnt;
    logic [GCNT_W-1:0]   r_valid, n_valid;
    logic [SAMPLE_W-1:0] r_peak,  n_peak;
    logic [LOCK_W-1:0]   r_lock,  n_lock;

    logic [GCNT_W-1:0]   group_n, need;
    logic [18:0]         s_x4, b_x5;
    logic [17:0]         p_x3, b_x4;
    logic [19:0]         b_x10;
    logic                hit, done, in_range;
    logic [SAMPLE_W-1:0] peak;
    logic [LOCK_W-1:0]   lk0, lk1;

    always_comb begin
        group_n = i_continuous ? GROUP_CONT : GROUP_SINGLE;
        need    = i_continuous ? NEED_CONT  : NEED_SINGLE;

        // s > b*5/4  <=>  4s > 5b
        s_x4 = {1'b0, i_sample, 2'b00};
        b_x5 = {1'b0, i_baseline, 2'b00} + {3'b000, i_baseline};
        hit  = (s_x4 > b_x5);

        n_valid = r_valid + GCNT_W'(hit);
        n_peak  = (i_sample > r_peak) ? i_sample : r_peak;
        n_gcnt  = r_gcnt + GCNT_W'(1);
        done    = (n_gcnt >= group_n);
        peak    = (n_valid >= need) ? n_peak : '0;

        // peak > b*4/3  <=>  3*peak > 4b
        p_x3     = {2'b00, peak} + {1'b0, peak, 1'b0};
        b_x4     = {i_baseline, 2'b00};
        b_x10    = {1'b0, i_baseline, 3'b000} + {3'b000, i_baseline, 1'b0};
        in_range = (p_x3 > b_x4) && ({4'b0000, peak} < b_x10);

        lk0    = i_continuous ? '0 : r_lock;
        lk1    = in_range ? LOCK_W'(LOCKOUT_SCANS) : lk0;
        n_lock = (lk1 != '0) ? lk1 - LOCK_W'(1) : '0;

        o_res.done    = done;
        o_res.pressed = in_range && (lk0 == '0);
        o_res.peak    = peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcnt  <= '0;
            r_valid <= '0;
            r_peak  <= '0;
            r_lock  <= '0;
        end else if (i_en) begin
            if (done) begin
                r_gcnt  <= '0;
                r_valid <= '0;
                r_peak  <= '0;
                r_lock  <= n_lock;
            end else begin
                r_gcnt  <= n_gcnt;
                r_valid <= n_valid;
                r_peak  <= n_peak;
            end
        end
    end

endmodule
